>>> design/tar_header_stream_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tar header stream parser.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TAR_HEADER_STREAM_PARSER_CORE_ASSERT_SVH
`define TAR_HEADER_STREAM_PARSER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge.
`define TSHP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define TSHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tshp_pkg.sv
// ----------------------------------------------------------------------------
// tshp_pkg
// Shared constants and types of the tar header stream parser: the block
// geometry, the ustar header field offsets, the record kinds and the header
// status bundle.
// ----------------------------------------------------------------------------
package tshp_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned SIZE_W      = 36;
  localparam int unsigned SKIP_W      = 37;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned CSUM_W      = 24;

  // Header field offsets inside a 512-byte block.
  localparam logic [POS_W-1:0] SIZE_FIRST  = 9'd124;
  localparam logic [POS_W-1:0] SIZE_END    = 9'd136;
  localparam logic [POS_W-1:0] CSUM_FIRST  = 9'd148;
  localparam logic [POS_W-1:0] CSUM_END    = 9'd156;
  localparam logic [POS_W-1:0] TYPE_POS    = 9'd156;
  localparam logic [POS_W-1:0] MAGIC_FIRST = 9'd257;
  localparam logic [POS_W-1:0] MAGIC_END   = 9'd262;
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] TYPE_FILE  = 8'h30;
  localparam logic [7:0] TYPE_DIR   = 8'h35;

  // Record kinds on the result channel.
  localparam logic [1:0] KIND_FILE = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  typedef struct packed {
    logic              name_empty;
    logic              hdr_ok;
    logic [7:0]        type_byte;
    logic [SIZE_W-1:0] size;
  } hdr_info_t;

  // The five characters of the ustar magic.
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h75;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h61;
      3'd4:    ch = 8'h72;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> design/tshp_in_if.sv
// ----------------------------------------------------------------------------
// tshp_in_if
// Archive byte channel: one archive byte per beat, with a flag on the last.
// ----------------------------------------------------------------------------
interface tshp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;
  logic       final_byte;

  modport source (output valid, output archive_byte, output final_byte, input ready);
  modport sink   (input valid, input archive_byte, input final_byte, output ready);
endinterface

>>> design/tshp_out_if.sv
// ----------------------------------------------------------------------------
// tshp_out_if
// Result channel: one entry, data or end record per beat.
// ----------------------------------------------------------------------------
interface tshp_out_if
  import tshp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        entry_type;
  logic [SIZE_W-1:0] entry_size;
  logic [7:0]        data_byte;
  logic              last_data;

  modport source (output valid, output kind, output entry_type, output entry_size,
                  output data_byte, output last_data, input ready);
  modport sink   (input valid, input kind, input entry_type, input entry_size,
                  input data_byte, input last_data, output ready);
endinterface

>>> design/tshp_hdr.sv
// ----------------------------------------------------------------------------
// tshp_hdr
// Header field collector: running byte sum, octal size and checksum fields,
// type flag, magic check and empty-name flag, updated one header byte a beat.
// ----------------------------------------------------------------------------
module tshp_hdr
  import tshp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             clear,
  input  logic [POS_W-1:0] pos,
  input  logic [7:0]       hdr_byte,
  output hdr_info_t        info
);

  logic [SUM_W-1:0]  byte_sum, byte_sum_next;
  logic [CSUM_W-1:0] stored_checksum, stored_checksum_next;
  logic              csum_stopped, csum_stopped_next;
  logic [SIZE_W-1:0] size_acc, size_acc_next;
  logic              size_stopped, size_stopped_next;
  logic              magic_matches, magic_matches_next;
  logic [7:0]        type_byte, type_byte_next;
  logic              name_empty, name_empty_next;

  logic              is_first, octal, in_size, in_csum, in_magic;
  logic [SUM_W-1:0]  base_sum;
  logic [CSUM_W-1:0] base_csum;
  logic              base_csum_stop, base_size_stop, base_magic;
  logic [SIZE_W-1:0] base_size;
  logic [7:0]        base_type, sum_byte;
  logic [2:0]        magic_idx;

  always_comb begin
    is_first  = (pos == '0);
    octal     = (hdr_byte >= CHAR_ZERO) && (hdr_byte <= CHAR_SEVEN);
    in_size   = (pos >= SIZE_FIRST) && (pos < SIZE_END);
    in_csum   = (pos >= CSUM_FIRST) && (pos < CSUM_END);
    in_magic  = (pos >= MAGIC_FIRST) && (pos < MAGIC_END);
    magic_idx = 3'(pos - MAGIC_FIRST);

    // The first byte of a header block starts from cleared fields.
    base_sum       = is_first ? '0 : byte_sum;
    base_csum      = is_first ? '0 : stored_checksum;
    base_csum_stop = is_first ? 1'b0 : csum_stopped;
    base_size      = is_first ? '0 : size_acc;
    base_size_stop = is_first ? 1'b0 : size_stopped;
    base_magic     = is_first ? 1'b1 : magic_matches;
    base_type      = is_first ? 8'h00 : type_byte;

    byte_sum_next        = byte_sum;
    stored_checksum_next = stored_checksum;
    csum_stopped_next    = csum_stopped;
    size_acc_next        = size_acc;
    size_stopped_next    = size_stopped;
    magic_matches_next   = magic_matches;
    type_byte_next       = type_byte;
    name_empty_next      = name_empty;

    if (step) begin
      // The checksum field itself counts as eight spaces.
      sum_byte      = in_csum ? CHAR_SPACE : hdr_byte;
      byte_sum_next = base_sum + SUM_W'(sum_byte);

      stored_checksum_next = base_csum;
      csum_stopped_next    = base_csum_stop;
      if (in_csum) begin
        if (!base_csum_stop && octal) begin
          stored_checksum_next = {base_csum[CSUM_W-4:0], hdr_byte[2:0]};
        end else begin
          csum_stopped_next = 1'b1;
        end
      end

      size_acc_next     = base_size;
      size_stopped_next = base_size_stop;
      if (in_size) begin
        if (!base_size_stop && octal) begin
          size_acc_next = {base_size[SIZE_W-4:0], hdr_byte[2:0]};
        end else begin
          size_stopped_next = 1'b1;
        end
      end

      type_byte_next = (pos == TYPE_POS) ? hdr_byte : base_type;

      magic_matches_next = base_magic;
      if (in_magic && (hdr_byte != magic_char(magic_idx))) begin
        magic_matches_next = 1'b0;
      end

      if (is_first) begin
        name_empty_next = (hdr_byte == 8'h00);
      end
    end else begin
      sum_byte = 8'h00;
    end

    info.name_empty = name_empty_next;
    info.hdr_ok     = magic_matches_next &&
                      ({{(CSUM_W-SUM_W){1'b0}}, byte_sum_next} == stored_checksum_next);
    info.type_byte  = type_byte_next;
    info.size       = size_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_sum        <= '0;
      stored_checksum <= '0;
      csum_stopped    <= 1'b0;
      size_acc        <= '0;
      size_stopped    <= 1'b0;
      magic_matches   <= 1'b1;
      type_byte       <= 8'h00;
      name_empty      <= 1'b0;
    end else begin
      byte_sum        <= byte_sum_next;
      stored_checksum <= stored_checksum_next;
      csum_stopped    <= csum_stopped_next;
      size_acc        <= size_acc_next;
      size_stopped    <= size_stopped_next;
      magic_matches   <= magic_matches_next;
      type_byte       <= type_byte_next;
      name_empty      <= name_empty_next;
    end
  end

endmodule

>>> design/tar_header_stream_parser_core.sv
// ----------------------------------------------------------------------------
// tar_header_stream_parser_core
// Streams a ustar archive one byte per beat and emits entry, data and end
// records. The block takes one archive byte every clock cycle, with no gaps,
// as long as the result side keeps up; each byte is registered on entry and
// its record, if any, lands in the result register when the byte is processed;
// processing waits while an earlier record is not yet taken. Throughput is
// set by the result register alone: while a record waits there, one more byte
// is held in the input register and then the archive side stalls. Header
// blocks produce at most one record (at their last byte), data bytes of a
// regular file produce one data record each, and padding, skipped blocks and
// everything after the end of the archive produce nothing. A beat with
// final_byte set returns the parser to its start state once handled.
// ----------------------------------------------------------------------------
module tar_header_stream_parser_core
  import tshp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tshp_in_if.sink    archive,
  tshp_out_if.source result
);

  `include "tar_header_stream_parser_core_assert.svh"

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ENDED  = 2'd2;

  localparam logic [SKIP_W-1:0] BLOCK_MASK = SKIP_W'(BLOCK_BYTES - 1);

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_final;

  // Parser state.
  logic [1:0]        phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [SIZE_W-1:0] data_left, data_left_next;
  logic [SKIP_W-1:0] skip_left, skip_left_next, skip_dec;

  // Result register.
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [7:0]        out_type;
  logic [SIZE_W-1:0] out_size;
  logic [7:0]        out_data;
  logic              out_last;

  logic              proc_fire, hdr_step, emit;
  logic [1:0]        emit_kind;
  logic [7:0]        emit_type;
  logic [SIZE_W-1:0] emit_size;
  logic [7:0]        emit_data;
  logic              emit_last;
  hdr_info_t         info;

  assign proc_fire     = in_full && (!out_valid || result.ready);
  assign archive.ready = !in_full || proc_fire;
  assign hdr_step      = proc_fire && (phase == PH_HEADER);

  tshp_hdr u_hdr (
    .clk      (clk),
    .rst      (rst),
    .step     (hdr_step),
    .clear    (proc_fire && in_final),
    .pos      (pos),
    .hdr_byte (in_byte),
    .info     (info)
  );

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    data_left_next = data_left;
    skip_left_next = skip_left;
    skip_dec       = skip_left;
    emit           = 1'b0;
    emit_kind      = KIND_END;
    emit_type      = 8'h00;
    emit_size      = '0;
    emit_data      = 8'h00;
    emit_last      = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        if (pos == LAST_POS) begin
          pos_next = '0;
          if (info.name_empty) begin
            emit       = 1'b1;
            emit_kind  = KIND_END;
            phase_next = PH_ENDED;
          end else if (info.hdr_ok) begin
            if ((info.type_byte == TYPE_FILE) || (info.type_byte == TYPE_DIR)) begin
              emit      = 1'b1;
              emit_kind = (info.type_byte == TYPE_FILE) ? KIND_FILE : KIND_DIR;
              emit_type = info.type_byte;
              emit_size = info.size;
            end
            data_left_next = (info.type_byte == TYPE_FILE) ? info.size : '0;
            // Data area rounded up to whole blocks.
            skip_left_next = ({1'b0, info.size} + BLOCK_MASK) & ~BLOCK_MASK;
            phase_next     = (skip_left_next != '0) ? PH_DATA : PH_HEADER;
          end
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      PH_DATA: begin
        if (data_left != '0) begin
          emit           = 1'b1;
          emit_kind      = KIND_DATA;
          emit_type      = info.type_byte;
          emit_size      = info.size;
          emit_data      = in_byte;
          emit_last      = (data_left == SIZE_W'(1));
          data_left_next = data_left - 1'b1;
        end
        if (skip_left != '0) begin
          skip_dec = skip_left - 1'b1;
        end
        skip_left_next = skip_dec;
        if (skip_dec == '0) begin
          data_left_next = '0;
          phase_next     = PH_HEADER;
          pos_next       = '0;
        end
      end
      default: begin
        // After the end record, bytes are dropped until the final beat.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (archive.valid && archive.ready) begin
      in_full <= 1'b1;
    end else if (proc_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (archive.valid && archive.ready) begin
      in_byte  <= archive.archive_byte;
      in_final <= archive.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (proc_fire && in_final)) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      data_left <= '0;
      skip_left <= '0;
    end else if (proc_fire) begin
      phase     <= phase_next;
      pos       <= pos_next;
      data_left <= data_left_next;
      skip_left <= skip_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_kind <= emit_kind;
      out_type <= emit_type;
      out_size <= emit_size;
      out_data <= emit_data;
      out_last <= emit_last;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.entry_type = out_type;
  assign result.entry_size = out_size;
  assign result.data_byte  = out_data;
  assign result.last_data  = out_last;

  // The data area always covers the remaining file bytes.
  `TSHP_ASSERT_ALWAYS(a_data_within_skip, ({1'b0, data_left} <= skip_left), "file bytes exceed data area")
  `TSHP_ASSERT_ALWAYS(a_data_phase_has_skip, (phase != PH_DATA) || (skip_left != '0), "data phase with empty data area")
  `TSHP_ASSERT_ALWAYS(a_pos_only_in_header, (pos == '0) || (phase == PH_HEADER), "block position moved outside a header")
  `TSHP_ASSERT_NEXT(a_mid_header_silent, proc_fire && (phase == PH_HEADER) && (pos != LAST_POS), !out_valid, "record emitted inside a header block")

endmodule
